// ===== src/hceb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hceb_pkg
// Shared types, constants and saturating helpers of the hyperchaotic byte
// generator.
// ----------------------------------------------------------------------------
package hceb_pkg;

    localparam int SW  = 48;           // state word width
    localparam int FB  = 32;           // fraction bits
    localparam int HW  = SW / 2;       // partial product operand width
    localparam int PW  = 2 * SW;       // full product width
    localparam int QW  = PW - FB;      // product width after the fraction shift
    localparam int CW  = 47;           // coefficient register width
    localparam int PSW = 32;           // scale register width
    localparam int AW  = 6;            // apb address width
    localparam int DW  = 64;           // apb data width

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    // half of the 0.001 step size, rounded to the fixed-point grid
    localparam logic [SW-1:0] HALF_DT =
        SW'((((64'd1 << FB) * 64'd5) + 64'd5000) / 64'd10000);

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_EMIT = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_A     = 3'd0,
        REG_B     = 3'd1,
        REG_C     = 3'd2,
        REG_D     = 3'd3,
        REG_E     = 3'd4,
        REG_F     = 3'd5,
        REG_G     = 3'd6,
        REG_SCALE = 3'd7
    } reg_idx_t;

    localparam logic [CW-1:0]  RST_A     = CW'(64'd8160437862);
    localparam logic [CW-1:0]  RST_B     = CW'(64'd51539607552);
    localparam logic [CW-1:0]  RST_C     = CW'(64'd128849018880);
    localparam logic [CW-1:0]  RST_D     = CW'(64'd8589934592);
    localparam logic [CW-1:0]  RST_E     = CW'(64'd17179869184);
    localparam logic [CW-1:0]  RST_F     = CW'(64'd429496730);
    localparam logic [CW-1:0]  RST_G     = CW'(64'd42949673);
    localparam logic [PSW-1:0] RST_SCALE = PSW'(64'd1000000);

    function automatic logic signed [SW-1:0] sat_add(logic signed [SW-1:0] a,
                                                     logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1]) return s[SW] ? SMIN : SMAX;
        return s[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat_sub(logic signed [SW-1:0] a,
                                                     logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} - {b[SW-1], b};
        if (s[SW] != s[SW-1]) return s[SW] ? SMIN : SMAX;
        return s[SW-1:0];
    endfunction

endpackage

// ===== src/hceb_fmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hceb_fmul
// Shared fixed-point multiplier: sign-magnitude, four half-width partial
// products accumulated over cycles, floor shift and saturation.
// ----------------------------------------------------------------------------
module hceb_fmul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [hceb_pkg::SW-1:0] op_a,
    input  logic signed [hceb_pkg::SW-1:0] op_b,
    output logic                        done,
    output logic signed [hceb_pkg::SW-1:0] result
);
    import hceb_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DRAIN, PH_FIN} phase_t;

    phase_t              phase_reg;
    logic [SW-1:0]       ma_reg, mb_reg;
    logic                neg_reg;
    logic [PW-1:0]       acc_reg;
    logic [SW-1:0]       pp_reg;
    logic [1:0]          pp_idx_reg;
    logic [1:0]          cnt_reg;
    logic                done_reg;
    logic signed [SW-1:0] result_reg;

    logic [HW-1:0]       a_half, b_half;
    logic [SW-1:0]       pp_next;
    logic [PW-1:0]       pp_shifted;
    logic [QW-1:0]       q;
    logic                frac_nz;
    logic [QW:0]         qq;
    logic signed [SW-1:0] res;

    always_comb begin
        a_half  = cnt_reg[1] ? ma_reg[SW-1:HW] : ma_reg[HW-1:0];
        b_half  = cnt_reg[0] ? mb_reg[SW-1:HW] : mb_reg[HW-1:0];
        pp_next = SW'(a_half) * SW'(b_half);
        unique case (pp_idx_reg)
            2'd0:    pp_shifted = PW'(pp_reg);
            2'd3:    pp_shifted = PW'(pp_reg) << SW;
            default: pp_shifted = PW'(pp_reg) << HW;
        endcase
    end

    // floor shift, then clamp to the state range
    always_comb begin
        q       = acc_reg[PW-1:FB];
        frac_nz = |acc_reg[FB-1:0];
        qq      = {1'b0, q} + (QW+1)'(frac_nz);
        if (!neg_reg) begin
            res = (q > QW'(SMAX)) ? SMAX : q[SW-1:0];
        end else begin
            res = (qq >= ((QW+1)'(1) << (SW-1))) ? SMIN : -qq[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE: begin
                    if (start) begin
                        ma_reg    <= op_a[SW-1] ? -op_a : op_a;
                        mb_reg    <= op_b[SW-1] ? -op_b : op_b;
                        neg_reg   <= op_a[SW-1] ^ op_b[SW-1];
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    pp_reg     <= pp_next;
                    pp_idx_reg <= cnt_reg;
                    cnt_reg    <= cnt_reg + 2'd1;
                    if (cnt_reg != 2'd0) acc_reg <= acc_reg + pp_shifted;
                    if (cnt_reg == 2'd3) phase_reg <= PH_DRAIN;
                end
                PH_DRAIN: begin
                    acc_reg   <= acc_reg + pp_shifted;
                    phase_reg <= PH_FIN;
                end
                PH_FIN: begin
                    result_reg <= res;
                    done_reg   <= 1'b1;
                    phase_reg  <= PH_IDLE;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/hyperchaotic_euler_byte_generator.sv =====
`timescale 1ns / 1ps
// sequence: a load copies the seeds; a step runs 16 products through the shared
//   multiplier one after another; an emit adds one product and then hands the
//   byte to the output register
// throughput: one item at a time; s_ready stays low while a step is in flight
// reset: synchronous active-low aresetn zeroes the trajectory, loads the
//   default coefficients and drops the output valid
// ----------------------------------------------------------------------------
// hyperchaotic_euler_byte_generator
// 5D memristive hyperchaotic system in Q16.32, advanced by Euler steps through
// one shared fixed-point multiplier, emitting a byte from the x0 fraction.
// ----------------------------------------------------------------------------
module hyperchaotic_euler_byte_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input item channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic signed [hceb_pkg::SW-1:0] s_seed_0,
    input  logic signed [hceb_pkg::SW-1:0] s_seed_1,
    input  logic signed [hceb_pkg::SW-1:0] s_seed_2,
    input  logic signed [hceb_pkg::SW-1:0] s_seed_3,
    input  logic signed [hceb_pkg::SW-1:0] s_seed_4,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hceb_pkg::AW-1:0]     paddr,
    input  logic [hceb_pkg::DW-1:0]     pwdata,
    output logic [hceb_pkg::DW-1:0]     prdata,
    output logic                        pready
);
    import hceb_pkg::*;

    // sequencer program: one product per step
    localparam logic [4:0] S_X1X2  = 5'd0;   // t = x1*x2
    localparam logic [4:0] S_AX0   = 5'd1;   // d0 = t - a*x0
    localparam logic [4:0] S_BX1   = 5'd2;   // t = b*x1
    localparam logic [4:0] S_X0X2  = 5'd3;   // d1 = t - x0*x2
    localparam logic [4:0] S_X0X1  = 5'd4;   // x01 = x0*x1
    localparam logic [4:0] S_CX2   = 5'd5;   // d2 = x01 - c*x2
    localparam logic [4:0] S_G3X4  = 5'd6;   // t = 3g*x4
    localparam logic [4:0] S_MEM   = 5'd7;   // t = f + t*x4
    localparam logic [4:0] S_DX3   = 5'd8;   // u = d*x3
    localparam logic [4:0] S_COUP  = 5'd9;   // d2 += u*t
    localparam logic [4:0] S_EX3   = 5'd10;  // d3 = x01 - e*x3, d4 = -x2
    localparam logic [4:0] S_UPD0  = 5'd11;  // x_i += d_i*HALF_DT, five steps
    localparam logic [4:0] S_UPD1  = 5'd12;
    localparam logic [4:0] S_UPD2  = 5'd13;
    localparam logic [4:0] S_UPD3  = 5'd14;
    localparam logic [4:0] S_UPD4  = 5'd15;
    localparam logic [4:0] S_BYTE  = 5'd16;  // frac(|x0|)*scale

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_PUSH} state_t;

    state_t               state_reg;
    logic [4:0]           step_reg;
    logic                 emit_reg;
    logic signed [SW-1:0] x_reg [5];
    logic signed [SW-1:0] d_reg [5];
    logic signed [SW-1:0] x01_reg, t_reg, u_reg;
    logic [7:0]           byte_hold_reg;
    logic                 m_valid_reg;
    logic [7:0]           m_byte_reg;

    // configuration registers
    logic [CW-1:0]        coeff_a_reg, coeff_b_reg, coeff_c_reg, coeff_d_reg;
    logic [CW-1:0]        coeff_e_reg, coeff_f_reg, coeff_g_reg;
    logic [PSW-1:0]       scale_reg;

    logic                 mul_start, mul_done;
    logic signed [SW-1:0] mul_a, mul_b, mul_res;
    logic signed [SW-1:0] g_ext, g3;
    logic [SW-1:0]        x0_mag;
    logic                 in_beat, cfg_wr;
    opcode_t              op;

    assign op      = opcode_t'(s_opcode);
    assign in_beat = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    assign g_ext  = SW'(coeff_g_reg);
    assign g3     = sat_add(sat_add(g_ext, g_ext), g_ext);
    assign x0_mag = x_reg[0][SW-1] ? -x_reg[0] : x_reg[0];

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            S_X1X2: begin mul_a = x_reg[1];           mul_b = x_reg[2]; end
            S_AX0:  begin mul_a = SW'(coeff_a_reg);   mul_b = x_reg[0]; end
            S_BX1:  begin mul_a = SW'(coeff_b_reg);   mul_b = x_reg[1]; end
            S_X0X2: begin mul_a = x_reg[0];           mul_b = x_reg[2]; end
            S_X0X1: begin mul_a = x_reg[0];           mul_b = x_reg[1]; end
            S_CX2:  begin mul_a = SW'(coeff_c_reg);   mul_b = x_reg[2]; end
            S_G3X4: begin mul_a = g3;                 mul_b = x_reg[4]; end
            S_MEM:  begin mul_a = t_reg;              mul_b = x_reg[4]; end
            S_DX3:  begin mul_a = SW'(coeff_d_reg);   mul_b = x_reg[3]; end
            S_COUP: begin mul_a = u_reg;              mul_b = t_reg;    end
            S_EX3:  begin mul_a = SW'(coeff_e_reg);   mul_b = x_reg[3]; end
            S_UPD0: begin mul_a = d_reg[0];           mul_b = HALF_DT;  end
            S_UPD1: begin mul_a = d_reg[1];           mul_b = HALF_DT;  end
            S_UPD2: begin mul_a = d_reg[2];           mul_b = HALF_DT;  end
            S_UPD3: begin mul_a = d_reg[3];           mul_b = HALF_DT;  end
            S_UPD4: begin mul_a = d_reg[4];           mul_b = HALF_DT;  end
            S_BYTE: begin
                // magnitude fraction times the integer scale, both positive
                mul_a = SW'(x0_mag[FB-1:0]);
                mul_b = SW'(scale_reg);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_start = (state_reg == ST_ISSUE);

    hceb_fmul u_fmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    // sequencer, trajectory and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= S_X1X2;
            emit_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++) x_reg[i] <= '0;
        end else begin
            // the push below refills the register itself when it drains
            if (m_valid_reg && m_ready && state_reg != ST_PUSH) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        unique case (op)
                            OP_LOAD: begin
                                x_reg[0] <= s_seed_0;
                                x_reg[1] <= s_seed_1;
                                x_reg[2] <= s_seed_2;
                                x_reg[3] <= s_seed_3;
                                x_reg[4] <= s_seed_4;
                            end
                            OP_STEP, OP_EMIT: begin
                                step_reg  <= S_X1X2;
                                emit_reg  <= (op == OP_EMIT);
                                state_reg <= ST_ISSUE;
                            end
                            default: ;  // unused opcode: dropped
                        endcase
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (mul_done) begin
                        unique case (step_reg)
                            S_X1X2: t_reg    <= mul_res;
                            S_AX0:  d_reg[0] <= sat_sub(t_reg, mul_res);
                            S_BX1:  t_reg    <= mul_res;
                            S_X0X2: d_reg[1] <= sat_sub(t_reg, mul_res);
                            S_X0X1: x01_reg  <= mul_res;
                            S_CX2:  d_reg[2] <= sat_sub(x01_reg, mul_res);
                            S_G3X4: t_reg    <= mul_res;
                            S_MEM:  t_reg    <= sat_add(SW'(coeff_f_reg), mul_res);
                            S_DX3:  u_reg    <= mul_res;
                            S_COUP: d_reg[2] <= sat_add(d_reg[2], mul_res);
                            S_EX3: begin
                                d_reg[3] <= sat_sub(x01_reg, mul_res);
                                d_reg[4] <= sat_sub('0, x_reg[2]);
                            end
                            S_UPD0: x_reg[0] <= sat_add(x_reg[0], mul_res);
                            S_UPD1: x_reg[1] <= sat_add(x_reg[1], mul_res);
                            S_UPD2: x_reg[2] <= sat_add(x_reg[2], mul_res);
                            S_UPD3: x_reg[3] <= sat_add(x_reg[3], mul_res);
                            S_UPD4: x_reg[4] <= sat_add(x_reg[4], mul_res);
                            S_BYTE: byte_hold_reg <= mul_res[7:0];
                            default: ;
                        endcase
                        priority if (step_reg == S_BYTE) begin
                            state_reg <= ST_PUSH;
                        end else if (step_reg == S_UPD4 && !emit_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            step_reg  <= step_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_PUSH: begin
                    // wait for room in the output register
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_byte_reg  <= byte_hold_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_a_reg <= RST_A;
            coeff_b_reg <= RST_B;
            coeff_c_reg <= RST_C;
            coeff_d_reg <= RST_D;
            coeff_e_reg <= RST_E;
            coeff_f_reg <= RST_F;
            coeff_g_reg <= RST_G;
            scale_reg   <= RST_SCALE;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[5:3]))
                REG_A:     coeff_a_reg <= pwdata[CW-1:0];
                REG_B:     coeff_b_reg <= pwdata[CW-1:0];
                REG_C:     coeff_c_reg <= pwdata[CW-1:0];
                REG_D:     coeff_d_reg <= pwdata[CW-1:0];
                REG_E:     coeff_e_reg <= pwdata[CW-1:0];
                REG_F:     coeff_f_reg <= pwdata[CW-1:0];
                REG_G:     coeff_g_reg <= pwdata[CW-1:0];
                REG_SCALE: scale_reg   <= pwdata[PSW-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx_t'(paddr[5:3]))
            REG_A:     prdata = DW'(coeff_a_reg);
            REG_B:     prdata = DW'(coeff_b_reg);
            REG_C:     prdata = DW'(coeff_c_reg);
            REG_D:     prdata = DW'(coeff_d_reg);
            REG_E:     prdata = DW'(coeff_e_reg);
            REG_F:     prdata = DW'(coeff_f_reg);
            REG_G:     prdata = DW'(coeff_g_reg);
            REG_SCALE: prdata = DW'(scale_reg);
            default:   prdata = '0;
        endcase
    end

    // a step beat must start the sequencer
    a_step_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && (op == OP_STEP || op == OP_EMIT) |=> state_reg == ST_ISSUE)
        else $error("step beat did not start the sequencer");

    // a load beat copies the first seed into x0
    a_load_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && op == OP_LOAD |=> x_reg[0] == $past(s_seed_0))
        else $error("load beat did not set x0");

    // multiplier finishes only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier result with no waiting step");

    // program counter stays inside the program
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> step_reg <= S_BYTE)
        else $error("step counter out of range");

    // the byte product is only reached on an emitting step
    a_byte_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE && step_reg == S_BYTE |-> emit_reg)
        else $error("byte product on a silent step");

endmodule
